/* hdl/acc_cpu_pkg.sv */
package acc_cpu_pkg;

    localparam int DATA_W         = 16;
    localparam int ADDR_W         = 12;
    localparam int WORD_COUNT_DEF = 256;
    localparam int DIV_STEPS      = 16;

    localparam logic [ADDR_W-1:0] PC_STEP = 12'h010;

    // request kinds
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_STEP  = 2'd2;
    localparam logic [1:0] REQ_RESET = 2'd3;

    // opcodes
    localparam logic [3:0] OP_JP  = 4'h0;
    localparam logic [3:0] OP_JZ  = 4'h1;
    localparam logic [3:0] OP_JN  = 4'h2;
    localparam logic [3:0] OP_LV  = 4'h3;
    localparam logic [3:0] OP_ADD = 4'h4;
    localparam logic [3:0] OP_SUB = 4'h5;
    localparam logic [3:0] OP_MUL = 4'h6;
    localparam logic [3:0] OP_DIV = 4'h7;
    localparam logic [3:0] OP_LD  = 4'h8;
    localparam logic [3:0] OP_MM  = 4'h9;
    localparam logic [3:0] OP_SC  = 4'hA;
    localparam logic [3:0] OP_RS  = 4'hB;
    localparam logic [3:0] OP_HM  = 4'hC;
    localparam logic [3:0] OP_GD  = 4'hD;
    localparam logic [3:0] OP_PD  = 4'hE;
    localparam logic [3:0] OP_OS  = 4'hF;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* hdl/acc_cpu_div.sv */
// Signed-by-unsigned restoring divider, one quotient bit per cycle.
module acc_cpu_div
    import acc_cpu_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] dividend,
    input  logic        [DATA_W-1:0] divisor,
    output logic        [DATA_W-1:0] quotient,
    output div_status_t              status
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] dvs_reg;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   trial;
    logic              fits;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // magnitude of -32768 is 0x8000, which still fits unsigned
    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[DATA_W-1];
            quo_reg <= dividend[DATA_W-1] ? DATA_W'(-dividend) : DATA_W'(dividend);
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], fits};
        end
    end

    assign quotient    = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* hdl/accumulator_cpu_step_top.sv */
// Channel  Dir  Handshake                       Payload
// s_axis   in   s_axis_tvalid / s_axis_tready   tuser: req_type; tdata: address,
//                                               write_data, get_data
// m_axis   out  m_axis_tvalid / m_axis_tready   tdata: read_data, accumulator,
//                                               prog_counter, halted, put_valid, div_error
//
// One request at a time. Write and register reset answer directly, a read after fetch,
// a step after fetch and any operand state; a divide step waits on the serial divider
// (one quotient bit per cycle). The word store has one write and one registered read port.
// Reset clears ac, pc, halt and the per-word valid bits (unwritten words read 0).
// A stalled result holds in the output register; the next request is taken
// meanwhile and waits in the response state only if the output is still full.
module accumulator_cpu_step_top
    import acc_cpu_pkg::*;
#(
    parameter int WORD_COUNT = WORD_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // address[11:0], write_data[27:12], get_data[43:28]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // read_data[15:0], accumulator[31:16],
                                        // prog_counter[43:32], halted[44],
                                        // put_valid[45], div_error[46]
);

    localparam int IDX_W = $clog2(WORD_COUNT);

    // word index = (bit address >> 4) mod WORD_COUNT, by reciprocal multiply;
    // exact for an 8-bit word number
    localparam int            RECIP   = (65536 + WORD_COUNT - 1) / WORD_COUNT;
    localparam logic [16:0]   RECIP_V = 17'(RECIP);
    localparam logic [8:0]    WC_V    = 9'(WORD_COUNT);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;   // read/fetch word on the read port
    localparam logic [2:0] S_OPER  = 3'd2;   // operand word on the read port
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    function automatic logic [IDX_W-1:0] widx(input logic [ADDR_W-1:0] a);
        logic [7:0]  w;
        logic [24:0] prod;
        logic [7:0]  q;
        logic [16:0] qw;
        logic [7:0]  rem;
        w    = a[ADDR_W-1:4];
        prod = 25'(w) * 25'(RECIP_V);
        q    = prod[23:16];
        qw   = 17'(q) * 17'(WC_V);
        rem  = w - qw[7:0];
        return rem[IDX_W-1:0];
    endfunction

    // input fields
    logic [1:0]        s_req;
    logic [ADDR_W-1:0] s_addr;
    logic [DATA_W-1:0] s_wdata;
    logic [DATA_W-1:0] s_gdata;
    logic              s_accept;

    assign s_req    = s_axis_tuser;
    assign s_addr   = s_axis_tdata[11:0];
    assign s_wdata  = s_axis_tdata[27:12];
    assign s_gdata  = s_axis_tdata[43:28];
    assign s_accept = s_axis_tvalid && s_axis_tready;

    // architectural and working registers
    logic [2:0]        state_reg, state_next;
    logic [1:0]        req_reg, req_next;
    logic [DATA_W-1:0] gdata_reg, gdata_next;
    logic [DATA_W-1:0] ins_reg, ins_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [ADDR_W-1:0] pc_reg, pc_next;
    logic              halt_reg, halt_next;
    logic [DATA_W-1:0] rdata_reg, rdata_next;
    logic              putv_reg, putv_next;
    logic              derr_reg, derr_next;
    logic              m_valid_reg, m_valid_next;
    logic [47:0]       m_data_reg;

    // word store: one write port, one registered read port, valid bit per word
    logic [DATA_W-1:0]     mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] vld_reg;
    logic [DATA_W-1:0]     rd_q_reg;
    logic                  vld_q_reg;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     wr_addr;
    logic [DATA_W-1:0]     wr_data;
    logic                  mem_we;
    logic [IDX_W-1:0]      rd_idx;
    logic [IDX_W-1:0]      wr_idx;
    logic [DATA_W-1:0]     rd_word;

    assign rd_idx  = widx(rd_addr);
    assign wr_idx  = widx(wr_addr);
    assign rd_word = vld_q_reg ? rd_q_reg : '0;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_idx] <= wr_data;
        end
        rd_q_reg  <= mem[rd_idx];
        vld_q_reg <= vld_reg[rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (mem_we) begin
            vld_reg[wr_idx] <= 1'b1;
        end
    end

    // serial divider for the divide step
    logic              div_start;
    logic [DATA_W-1:0] div_quo;
    div_status_t       div_stat;

    acc_cpu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ($signed(acc_reg)),
        .divisor  (rd_word),
        .quotient (div_quo),
        .status   (div_stat)
    );

    // datapath helpers
    logic [ADDR_W-1:0]   pc_inc;
    logic [2*DATA_W-1:0] mul_full;
    logic [ADDR_W-1:0]   f_opd;
    logic [3:0]          f_opc;
    logic [3:0]          o_opc;
    logic                out_load;

    assign pc_inc   = pc_reg + PC_STEP;
    assign mul_full = (2*DATA_W)'(acc_reg) * (2*DATA_W)'(rd_word);
    assign f_opd    = rd_word[ADDR_W-1:0];
    assign f_opc    = rd_word[DATA_W-1:ADDR_W];
    assign o_opc    = ins_reg[DATA_W-1:ADDR_W];
    assign out_load = (state_reg == S_RESP) && (!m_valid_reg || m_axis_tready);

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        gdata_next = gdata_reg;
        ins_next   = ins_reg;
        acc_next   = acc_reg;
        pc_next    = pc_reg;
        halt_next  = halt_reg;
        rdata_next = rdata_reg;
        putv_next  = putv_reg;
        derr_next  = derr_reg;
        rd_addr    = pc_reg;
        wr_addr    = s_addr;
        wr_data    = s_wdata;
        mem_we     = 1'b0;
        div_start  = 1'b0;

        case (state_reg)
            S_IDLE: begin
                rd_addr = (s_req == REQ_STEP) ? pc_reg : s_addr;
                if (s_accept) begin
                    req_next   = s_req;
                    gdata_next = s_gdata;
                    putv_next  = 1'b0;
                    derr_next  = 1'b0;
                    case (s_req)
                        REQ_WRITE: begin
                            mem_we     = 1'b1;
                            rdata_next = s_wdata;
                            state_next = S_RESP;
                        end
                        REQ_RESET: begin
                            acc_next   = '0;
                            pc_next    = '0;
                            halt_next  = 1'b0;
                            rdata_next = '0;
                            state_next = S_RESP;
                        end
                        default: begin
                            state_next = S_FETCH;
                        end
                    endcase
                end
            end

            S_FETCH: begin
                rd_addr    = f_opd;
                wr_addr    = f_opd;
                wr_data    = acc_reg;
                rdata_next = rd_word;
                ins_next   = rd_word;
                state_next = S_RESP;
                if (req_reg == REQ_STEP && !halt_reg) begin
                    // a word equal to pc stops the machine
                    if (rd_word == DATA_W'(pc_reg)) begin
                        halt_next = 1'b1;
                    end else begin
                        case (f_opc)
                            OP_JP: pc_next = f_opd;
                            OP_JZ: pc_next = (acc_reg == '0) ? f_opd : pc_inc;
                            OP_JN: pc_next = acc_reg[DATA_W-1] ? f_opd : pc_inc;
                            OP_LV: begin
                                acc_next = {{(DATA_W-ADDR_W){f_opd[ADDR_W-1]}}, f_opd};
                                pc_next  = pc_inc;
                            end
                            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LD, OP_RS: begin
                                state_next = S_OPER;
                            end
                            OP_MM: begin
                                mem_we  = 1'b1;
                                pc_next = pc_inc;
                            end
                            OP_SC: begin
                                mem_we  = 1'b1;
                                wr_data = DATA_W'(pc_inc);
                                pc_next = f_opd + PC_STEP;
                            end
                            OP_HM: begin
                                pc_next   = f_opd;
                                halt_next = 1'b1;
                            end
                            OP_GD: begin
                                acc_next = gdata_reg;
                                pc_next  = pc_inc;
                            end
                            OP_PD: begin
                                putv_next = 1'b1;
                                pc_next   = pc_inc;
                            end
                            default: ;   // OS: nothing moves
                        endcase
                    end
                end
            end

            S_OPER: begin
                state_next = S_RESP;
                pc_next    = pc_inc;
                case (o_opc)
                    OP_ADD: acc_next = acc_reg + rd_word;
                    OP_SUB: acc_next = acc_reg - rd_word;
                    OP_MUL: acc_next = mul_full[DATA_W-1:0];
                    OP_LD:  acc_next = rd_word;
                    OP_RS:  pc_next  = rd_word[ADDR_W-1:0];
                    OP_DIV: begin
                        if (rd_word == '0) begin
                            derr_next = 1'b1;
                        end else begin
                            div_start  = 1'b1;
                            pc_next    = pc_reg;
                            state_next = S_DIV;
                        end
                    end
                    default: ;
                endcase
            end

            S_DIV: begin
                if (div_stat.done) begin
                    acc_next   = div_quo;
                    pc_next    = pc_inc;
                    state_next = S_RESP;
                end
            end

            S_RESP: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            acc_reg     <= '0;
            pc_reg      <= '0;
            halt_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            pc_reg      <= pc_next;
            halt_reg    <= halt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        gdata_reg <= gdata_next;
        ins_reg   <= ins_next;
        rdata_reg <= rdata_next;
        putv_reg  <= putv_next;
        derr_reg  <= derr_next;
        if (out_load) begin
            m_data_reg <= {1'b0, derr_reg, putv_reg, halt_reg, pc_reg, acc_reg, rdata_reg};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_axis_tready)
        else $error("request taken while previous one still in flight");

    a_div_only_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> state_reg == S_DIV)
        else $error("divider running outside divide state");

    a_halt_from_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(halt_reg) |-> $past(state_reg) == S_FETCH)
        else $error("halt set outside instruction fetch");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tdata[45] && m_axis_tdata[46]))
        else $error("put and divide error flagged together");
`endif

endmodule
